>>> sv/fsw_pkg.sv
// shared types and constants of the fragmenting stop-and-wait sender
package fsw_pkg;

  // fixed field widths
  localparam int LEN_W   = 13;
  localparam int ID_W    = 8;
  localparam int KIND_W  = 2;
  localparam int OFF_W   = 12;
  localparam int PLEN_W  = 8;
  localparam int TIMER_W = 16;

  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;

  // operation codes of an input transfer
  typedef enum logic [2:0] {
    FUNC_PUT    = 3'd0,
    FUNC_ACK_OK = 3'd1,
    FUNC_ACK_ER = 3'd2,
    FUNC_RESEND = 3'd3,
    FUNC_TICK   = 3'd4
  } func_t;

  // packet size classes
  typedef enum logic [KIND_W-1:0] {
    KIND_SMALL  = 2'd0,
    KIND_MEDIUM = 2'd1,
    KIND_LARGE  = 2'd2
  } kind_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_ACK,
    ST_WAIT,
    ST_SEND,
    ST_FINISH
  } state_t;

  // one queued packet descriptor
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  offset;
    logic [PLEN_W-1:0] length;
    logic              chained;
  } desc_t;

endpackage

>>> sv/fsw_ram.sv
// generic single-port-write ram with registered read
module fsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/fragmenting_stop_and_wait_sender.sv
// top level: message splitter, descriptor queue and stop-and-wait retransmit control
//
// Each input transfer is one operation (put, ack ok, ack error, resend request,
// tick) and yields at most one result transfer carrying the sent descriptor
// and/or the overflow flag. The block handles one operation at a time and
// drops in_ready until it is done. A put walks the message with one shared
// subtract/compare unit, one fragment per cycle, and passes ST_FINISH only
// when it yields a result. A matching ok acknowledgement passes ST_ACK,
// ST_WAIT, ST_SEND and ST_FINISH (no ST_FINISH when it empties the queue) and
// a mismatched one only ST_ACK; error, resend and a firing tick pass ST_SEND
// and ST_FINISH, or only ST_SEND on an empty queue, since the head descriptor
// comes from a queue RAM with a registered read. Non-firing ticks and ignored
// operations finish in the idle state. A result that the consumer has not
// taken holds the block in its final cycle.
// The timeout register may be written at any idle time; a value of zero acts
// as one.
module fragmenting_stop_and_wait_sender #(
  parameter int SMALL_PAYLOAD  = 8,
  parameter int MEDIUM_PAYLOAD = 32,
  parameter int LARGE_PAYLOAD  = 128,
  parameter int QUEUE_DEPTH    = 32,
  parameter int MAX_MESSAGE    = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [fsw_pkg::TIMER_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     func,
  input  logic [fsw_pkg::LEN_W-1:0]      message_length,
  input  logic [fsw_pkg::ID_W-1:0]       ack_id,
  // output channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           sent,
  output logic [fsw_pkg::ID_W-1:0]       pkt_id,
  output logic [fsw_pkg::KIND_W-1:0]     pkt_kind,
  output logic [fsw_pkg::OFF_W-1:0]      pkt_offset,
  output logic [fsw_pkg::PLEN_W-1:0]     pkt_length,
  output logic                           chained,
  output logic                           overflow
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CLIP_W = 17;

  localparam logic [fsw_pkg::LEN_W-1:0] LARGE_LEN  = fsw_pkg::LEN_W'(LARGE_PAYLOAD);
  localparam logic [fsw_pkg::LEN_W-1:0] MEDIUM_LEN = fsw_pkg::LEN_W'(MEDIUM_PAYLOAD);
  localparam logic [fsw_pkg::LEN_W-1:0] SMALL_LEN  = fsw_pkg::LEN_W'(SMALL_PAYLOAD);
  localparam logic [fsw_pkg::LEN_W-1:0] MAX_LEN    = fsw_pkg::LEN_W'(MAX_MESSAGE);
  localparam logic [PTR_W-1:0]          PTR_LAST   = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0]          CNT_FULL   = CNT_W'(QUEUE_DEPTH);

  // registers
  fsw_pkg::state_t                state, state_next;
  logic [fsw_pkg::TIMER_W-1:0]    timeout_ticks;
  logic [fsw_pkg::ID_W-1:0]       next_seq, next_seq_next;
  logic [PTR_W-1:0]               queue_head, queue_head_next;
  logic [PTR_W-1:0]               queue_tail, queue_tail_next;
  logic [CNT_W-1:0]               queue_count, queue_count_next;
  logic                           timer_armed, timer_armed_next;
  logic [fsw_pkg::TIMER_W-1:0]    timer_left, timer_left_next;
  logic [fsw_pkg::LEN_W-1:0]      remain, remain_next;
  logic [fsw_pkg::LEN_W-1:0]      offset, offset_next;
  logic [fsw_pkg::ID_W-1:0]       ack_q, ack_q_next;
  logic                           res_sent, res_sent_next;
  logic                           res_ovf, res_ovf_next;
  fsw_pkg::desc_t                 res_desc, res_desc_next;
  logic                           out_valid_next;
  logic                           out_sent, out_sent_next;
  logic                           out_ovf, out_ovf_next;
  fsw_pkg::desc_t                 out_desc, out_desc_next;

  // queue memory signals
  logic                           wr_en;
  fsw_pkg::desc_t                 wr_desc;
  fsw_pkg::desc_t                 rd_desc;
  logic [$bits(fsw_pkg::desc_t)-1:0] rd_bits;

  // datapath helpers
  logic [fsw_pkg::LEN_W-1:0]      len_clip;
  fsw_pkg::desc_t                 frag;
  logic                           frag_more;
  logic [PTR_W-1:0]               head_inc;
  logic [PTR_W-1:0]               tail_inc;
  logic                           out_free;

  fsw_ram #(
    .WIDTH ($bits(fsw_pkg::desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .we    (wr_en),
    .waddr (queue_tail),
    .wdata (wr_desc),
    .raddr (queue_head),
    .rdata (rd_bits)
  );

  assign rd_desc = fsw_pkg::desc_t'(rd_bits);

  // length clip to the largest message
  assign len_clip = ({{(CLIP_W - fsw_pkg::LEN_W){1'b0}}, message_length} > CLIP_W'(MAX_MESSAGE))
                    ? MAX_LEN : message_length;

  // fragment cut by the shared compare unit
  always_comb begin
    frag_more      = remain > LARGE_LEN;
    frag.id        = next_seq;
    frag.offset    = offset[fsw_pkg::OFF_W-1:0];
    if (frag_more) begin
      frag.kind    = fsw_pkg::KIND_LARGE;
      frag.length  = LARGE_LEN[fsw_pkg::PLEN_W-1:0];
      frag.chained = 1'b1;
    end else begin
      if (remain > MEDIUM_LEN) begin
        frag.kind  = fsw_pkg::KIND_LARGE;
      end else if (remain > SMALL_LEN) begin
        frag.kind  = fsw_pkg::KIND_MEDIUM;
      end else begin
        frag.kind  = fsw_pkg::KIND_SMALL;
      end
      frag.length  = remain[fsw_pkg::PLEN_W-1:0];
      frag.chained = 1'b0;
    end
  end

  // pointer wrap
  assign head_inc = (queue_head == PTR_LAST) ? '0 : queue_head + 1'b1;
  assign tail_inc = (queue_tail == PTR_LAST) ? '0 : queue_tail + 1'b1;

  assign out_free = !out_valid || out_ready;

  // sequencer: next state and datapath updates
  always_comb begin
    state_next       = state;
    next_seq_next    = next_seq;
    queue_head_next  = queue_head;
    queue_tail_next  = queue_tail;
    queue_count_next = queue_count;
    timer_armed_next = timer_armed;
    timer_left_next  = timer_left;
    remain_next      = remain;
    offset_next      = offset;
    ack_q_next       = ack_q;
    res_sent_next    = res_sent;
    res_ovf_next     = res_ovf;
    res_desc_next    = res_desc;
    out_valid_next   = out_valid && !out_ready;
    out_sent_next    = out_sent;
    out_ovf_next     = out_ovf;
    out_desc_next    = out_desc;
    wr_en            = 1'b0;
    wr_desc          = frag;
    in_ready         = 1'b0;

    case (state)
      fsw_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          ack_q_next    = ack_id;
          remain_next   = len_clip;
          offset_next   = '0;
          res_sent_next = 1'b0;
          res_ovf_next  = 1'b0;
          res_desc_next = '0;
          case (fsw_pkg::func_t'(func))
            fsw_pkg::FUNC_PUT: begin
              if (len_clip != '0) begin
                state_next = fsw_pkg::ST_PUT;
              end
            end
            fsw_pkg::FUNC_ACK_OK: begin
              timer_armed_next = 1'b0;
              state_next       = fsw_pkg::ST_ACK;
            end
            fsw_pkg::FUNC_ACK_ER: begin
              timer_armed_next = 1'b0;
              state_next       = fsw_pkg::ST_SEND;
            end
            fsw_pkg::FUNC_RESEND: begin
              state_next = fsw_pkg::ST_SEND;
            end
            fsw_pkg::FUNC_TICK: begin
              if (timer_armed) begin
                if (timer_left > fsw_pkg::TIMER_W'(1)) begin
                  timer_left_next = timer_left - 1'b1;
                end else begin
                  // timeout fires as an error acknowledgement
                  timer_left_next  = '0;
                  timer_armed_next = 1'b0;
                  state_next       = fsw_pkg::ST_SEND;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one fragment per cycle
      fsw_pkg::ST_PUT: begin
        next_seq_next = next_seq + 1'b1;
        if (queue_count == '0) begin
          res_sent_next    = 1'b1;
          res_desc_next    = frag;
          timer_armed_next = 1'b1;
          timer_left_next  = timeout_ticks;
        end
        if (queue_count < CNT_FULL) begin
          wr_en            = 1'b1;
          queue_tail_next  = tail_inc;
          queue_count_next = queue_count + 1'b1;
        end else begin
          res_ovf_next = 1'b1;
        end
        if (frag_more) begin
          remain_next = remain - LARGE_LEN;
          offset_next = offset + LARGE_LEN;
        end else if (res_sent_next || res_ovf_next) begin
          state_next = fsw_pkg::ST_FINISH;
        end else begin
          state_next = fsw_pkg::ST_IDLE;
        end
      end

      // ok acknowledgement: head data is ready from the ram
      fsw_pkg::ST_ACK: begin
        if (queue_count != '0 && rd_desc.id == ack_q) begin
          queue_head_next  = head_inc;
          queue_count_next = queue_count - 1'b1;
          state_next       = fsw_pkg::ST_WAIT;
        end else begin
          state_next = fsw_pkg::ST_IDLE;
        end
      end

      // ram read of the new head
      fsw_pkg::ST_WAIT: begin
        state_next = fsw_pkg::ST_SEND;
      end

      // send the head if there is one
      fsw_pkg::ST_SEND: begin
        if (queue_count != '0) begin
          res_sent_next    = 1'b1;
          res_desc_next    = rd_desc;
          timer_armed_next = 1'b1;
          timer_left_next  = timeout_ticks;
          state_next       = fsw_pkg::ST_FINISH;
        end else begin
          state_next = fsw_pkg::ST_IDLE;
        end
      end

      // hand the result to the output register
      fsw_pkg::ST_FINISH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_sent_next  = res_sent;
          out_ovf_next   = res_ovf;
          out_desc_next  = res_desc;
          state_next     = fsw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = fsw_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fsw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= fsw_pkg::TIMEOUT_RESET;
      next_seq      <= '0;
      queue_head    <= '0;
      queue_tail    <= '0;
      queue_count   <= '0;
      timer_armed   <= 1'b0;
      timer_left    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_ticks <= cfg_wr_data;
      end
      next_seq    <= next_seq_next;
      queue_head  <= queue_head_next;
      queue_tail  <= queue_tail_next;
      queue_count <= queue_count_next;
      timer_armed <= timer_armed_next;
      timer_left  <= timer_left_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    remain   <= remain_next;
    offset   <= offset_next;
    ack_q    <= ack_q_next;
    res_sent <= res_sent_next;
    res_ovf  <= res_ovf_next;
    res_desc <= res_desc_next;
    out_sent <= out_sent_next;
    out_ovf  <= out_ovf_next;
    out_desc <= out_desc_next;
  end

  // output ports
  assign sent       = out_sent;
  assign pkt_id     = out_desc.id;
  assign pkt_kind   = out_desc.kind;
  assign pkt_offset = out_desc.offset;
  assign pkt_length = out_desc.length;
  assign chained    = out_desc.chained;
  assign overflow   = out_ovf;

  // an accepted put of nonzero length moves to ST_PUT in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && fsw_pkg::func_t'(func) == fsw_pkg::FUNC_PUT &&
     message_length != '0) |=> state == fsw_pkg::ST_PUT)
    else $error("put did not start the splitter");

  // a result without a descriptor must be an overflow report with clear fields
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sent) |-> (overflow && pkt_id == '0 && pkt_length == '0 && !chained))
    else $error("result without descriptor is not a clean overflow report");

  // pointers agree with the fill count at empty and full
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (queue_count == '0 || queue_count == CNT_FULL) |-> queue_head == queue_tail)
    else $error("queue pointers disagree with count");

  // sending the head always arms the timer
  a_send_arms: assert property (@(posedge clk) disable iff (rst)
    (state == fsw_pkg::ST_SEND && queue_count != '0) |=>
    (timer_armed && timer_left == $past(timeout_ticks)))
    else $error("head send did not arm the timer");

  // queue never exceeds its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == fsw_pkg::ST_PUT && queue_count == CNT_FULL) |=> queue_count == CNT_FULL)
    else $error("push into a full queue");

endmodule

>>> tb/sv/sender_checker.sv
`timescale 1ns / 100ps
// checker: watches both channels, predicts each result transfer and compares it
module sender_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [fsw_pkg::TIMER_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  func,
  input  logic [fsw_pkg::LEN_W-1:0]   message_length,
  input  logic [fsw_pkg::ID_W-1:0]    ack_id,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        sent,
  input  logic [fsw_pkg::ID_W-1:0]    pkt_id,
  input  logic [fsw_pkg::KIND_W-1:0]  pkt_kind,
  input  logic [fsw_pkg::OFF_W-1:0]   pkt_offset,
  input  logic [fsw_pkg::PLEN_W-1:0]  pkt_length,
  input  logic                        chained,
  input  logic                        overflow,
  output int unsigned                 error_count,
  output int unsigned                 pending_count
);

  localparam int SMALL_PL  = 8;
  localparam int MEDIUM_PL = 32;
  localparam int LARGE_PL  = 128;
  localparam int RING_SIZE = 32;
  localparam int MAX_MSG   = 4096;

  // one result transfer as the block should present it
  typedef struct packed {
    logic           sent;
    fsw_pkg::desc_t pkt;
    logic           overflow;
  } tx_result_t;

  // predicted sender state
  logic [fsw_pkg::ID_W-1:0]    seq_ctr = '0;
  fsw_pkg::desc_t              pkt_ring [RING_SIZE];
  logic [4:0]                  ring_head = '0;
  logic [5:0]                  ring_level = '0;
  logic                        retx_armed = 1'b0;
  logic [fsw_pkg::TIMER_W-1:0] retx_left = '0;
  logic [fsw_pkg::TIMER_W-1:0] retx_timeout = fsw_pkg::TIMEOUT_RESET;

  tx_result_t  due_results [$];
  int unsigned errors = 0;

  function automatic void arm_retx();
    retx_armed = 1'b1;
    retx_left = retx_timeout;
  endfunction

  // head descriptor goes out again, timer restarts
  function automatic bit send_head(inout tx_result_t r);
    if (ring_level == 0) return 1'b0;
    r.sent = 1'b1;
    r.pkt = pkt_ring[ring_head];
    arm_retx();
    return 1'b1;
  endfunction

  // one fragment takes an id; first one on an empty ring goes out at once
  function automatic void add_fragment(fsw_pkg::kind_t k, int unsigned off, int unsigned n,
                                       logic ch, inout tx_result_t r, inout bit has,
                                       inout bit dropped);
    fsw_pkg::desc_t d;
    d.id = seq_ctr;
    d.kind = k;
    d.offset = fsw_pkg::OFF_W'(off);
    d.length = fsw_pkg::PLEN_W'(n);
    d.chained = ch;
    seq_ctr = seq_ctr + 1'b1;
    if (ring_level == 0) begin
      r.sent = 1'b1;
      r.pkt = d;
      arm_retx();
      has = 1'b1;
    end
    if (ring_level < RING_SIZE) begin
      pkt_ring[(int'(ring_head) + int'(ring_level)) % RING_SIZE] = d;
      ring_level = ring_level + 1'b1;
    end else begin
      dropped = 1'b1;
    end
  endfunction

  // expected result of one accepted operation, if any
  function automatic void predict_send(logic [2:0] op, logic [fsw_pkg::LEN_W-1:0] len,
                                       logic [fsw_pkg::ID_W-1:0] aid);
    tx_result_t  r;
    bit          has;
    bit          dropped;
    int unsigned left;
    int unsigned off;
    logic [2:0]  eff;
    r = '0;
    has = 1'b0;
    dropped = 1'b0;
    eff = op;
    if (op == fsw_pkg::FUNC_PUT) begin
      left = (len > MAX_MSG) ? MAX_MSG : len;
      if (left != 0) begin
        off = 0;
        while (left > LARGE_PL) begin
          add_fragment(fsw_pkg::KIND_LARGE, off, LARGE_PL, 1'b1, r, has, dropped);
          off += LARGE_PL;
          left -= LARGE_PL;
        end
        if (left > MEDIUM_PL)
          add_fragment(fsw_pkg::KIND_LARGE, off, left, 1'b0, r, has, dropped);
        else if (left > SMALL_PL)
          add_fragment(fsw_pkg::KIND_MEDIUM, off, left, 1'b0, r, has, dropped);
        else
          add_fragment(fsw_pkg::KIND_SMALL, off, left, 1'b0, r, has, dropped);
        if (dropped) begin
          r.overflow = 1'b1;
          has = 1'b1;
        end
      end
    end else begin
      // an expiring timer acts as an error acknowledgement
      if (op == fsw_pkg::FUNC_TICK && retx_armed) begin
        if (retx_left > 1) begin
          retx_left = retx_left - 1'b1;
        end else begin
          retx_left = '0;
          eff = fsw_pkg::FUNC_ACK_ER;
        end
      end
      case (eff)
        fsw_pkg::FUNC_ACK_OK: begin
          retx_armed = 1'b0;
          if (ring_level != 0 && pkt_ring[ring_head].id == aid) begin
            ring_head = ring_head + 1'b1;
            ring_level = ring_level - 1'b1;
            has = send_head(r);
          end
        end
        fsw_pkg::FUNC_ACK_ER: begin
          retx_armed = 1'b0;
          has = send_head(r);
        end
        fsw_pkg::FUNC_RESEND: has = send_head(r);
        default: ;
      endcase
    end
    if (has) due_results.insert(due_results.size(), r);
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t sender_checker: %s expected %0h got %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  // sample both channels at each edge
  always @(posedge clk) begin : watch
    tx_result_t want;
    if (rst) begin
      seq_ctr = '0;
      ring_head = '0;
      ring_level = '0;
      retx_armed = 1'b0;
      retx_left = '0;
      retx_timeout = fsw_pkg::TIMEOUT_RESET;
      due_results.delete();
    end else begin
      if (cfg_wr_en) retx_timeout = cfg_wr_data;
      // result transfer against the oldest expectation
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t sender_checker: result with nothing expected, expected none got id %0h",
                   $time, pkt_id);
          errors++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          check_field("sent", want.sent, sent);
          check_field("pkt_id", want.pkt.id, pkt_id);
          check_field("pkt_kind", want.pkt.kind, pkt_kind);
          check_field("pkt_offset", want.pkt.offset, pkt_offset);
          check_field("pkt_length", want.pkt.length, pkt_length);
          check_field("chained", want.pkt.chained, chained);
          check_field("overflow", want.overflow, overflow);
        end
      end
      // input transfer feeds the prediction
      if (in_valid && in_ready) predict_send(func, message_length, ack_id);
    end
    error_count <= errors;
    pending_count <= due_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, stimulus, idling and verdict for the fragmenting sender
module tb_top;

  localparam int SETTLE_CYCLES = 40;
  localparam int LARGE_PL      = 128;
  localparam int RING_SIZE     = 32;
  localparam int MAX_MSG       = 4096;
  localparam int PHASE_ITEMS   = 312;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_wr_en = 1'b0;
  logic [fsw_pkg::TIMER_W-1:0] cfg_wr_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [2:0]                  func = fsw_pkg::FUNC_PUT;
  logic [fsw_pkg::LEN_W-1:0]   message_length = '0;
  logic [fsw_pkg::ID_W-1:0]    ack_id = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        sent;
  logic [fsw_pkg::ID_W-1:0]    pkt_id;
  logic [fsw_pkg::KIND_W-1:0]  pkt_kind;
  logic [fsw_pkg::OFF_W-1:0]   pkt_offset;
  logic [fsw_pkg::PLEN_W-1:0]  pkt_length;
  logic                        chained;
  logic                        overflow;
  int unsigned                 error_count;
  int unsigned                 pending_count;

  // idling enable and a rough copy of the queued ids for matching acks
  logic                     gaps_on = 1'b1;
  int unsigned              stall_left = 0;
  logic [fsw_pkg::ID_W-1:0] id_next = '0;
  logic [fsw_pkg::ID_W-1:0] queued_ids [$];

  fragmenting_stop_and_wait_sender dut (.*);
  sender_checker checker_i (.*);

  always #1 clk = ~clk;

  // result side: stall bursts of random length while idling is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (gaps_on && !rst && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // follow ids so that most ok acks name the head
  function automatic void track_ids(logic [2:0] op, logic [fsw_pkg::LEN_W-1:0] len,
                                    logic [fsw_pkg::ID_W-1:0] aid);
    int unsigned left;
    int unsigned n;
    if (op == fsw_pkg::FUNC_PUT) begin
      left = (len > MAX_MSG) ? MAX_MSG : len;
      n = (left == 0) ? 0 : (left - 1) / LARGE_PL + 1;
      repeat (n) begin
        if (queued_ids.size() < RING_SIZE) queued_ids.insert(queued_ids.size(), id_next);
        id_next = id_next + 1'b1;
      end
    end else if (op == fsw_pkg::FUNC_ACK_OK && queued_ids.size() != 0 &&
                 queued_ids[0] == aid) begin
      queued_ids.delete(0);
    end
  endfunction

  function automatic logic [fsw_pkg::ID_W-1:0] head_id();
    if (queued_ids.size() != 0) return queued_ids[0];
    return fsw_pkg::ID_W'($urandom);
  endfunction

  // mostly short messages, a few long or clipped ones
  function automatic logic [fsw_pkg::LEN_W-1:0] pick_length();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 2) return '0;
    if (p < 60) return fsw_pkg::LEN_W'($urandom_range(1, 40));
    if (p < 88) return fsw_pkg::LEN_W'($urandom_range(41, 400));
    if (p < 96) return fsw_pkg::LEN_W'($urandom_range(401, MAX_MSG));
    return fsw_pkg::LEN_W'($urandom_range(MAX_MSG + 1, (1 << fsw_pkg::LEN_W) - 1));
  endfunction

  // one input transfer, with an optional idle burst ahead of it
  task automatic send_op(input logic [2:0] op, input logic [fsw_pkg::LEN_W-1:0] len,
                         input logic [fsw_pkg::ID_W-1:0] aid);
    int unsigned gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    message_length <= len;
    ack_id <= aid;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_ids(op, len, aid);
  endtask

  task automatic random_op(output bit counted);
    int unsigned               pick;
    logic [fsw_pkg::LEN_W-1:0] len;
    pick = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 28) begin
      len = pick_length();
      counted = (len != 0);
      send_op(fsw_pkg::FUNC_PUT, len, fsw_pkg::ID_W'($urandom));
    end else if (pick < 62) begin
      send_op(fsw_pkg::FUNC_ACK_OK, fsw_pkg::LEN_W'($urandom), head_id());
    end else if (pick < 68) begin
      send_op(fsw_pkg::FUNC_ACK_OK, fsw_pkg::LEN_W'($urandom), fsw_pkg::ID_W'($urandom));
    end else if (pick < 75) begin
      send_op(fsw_pkg::FUNC_ACK_ER, fsw_pkg::LEN_W'($urandom), fsw_pkg::ID_W'($urandom));
    end else if (pick < 82) begin
      send_op(fsw_pkg::FUNC_RESEND, fsw_pkg::LEN_W'($urandom), fsw_pkg::ID_W'($urandom));
    end else if (pick < 97) begin
      send_op(fsw_pkg::FUNC_TICK, fsw_pkg::LEN_W'($urandom), fsw_pkg::ID_W'($urandom));
    end else begin
      // unused operation codes above tick
      counted = 1'b0;
      send_op(3'(fsw_pkg::FUNC_TICK + $urandom_range(1, 3)), fsw_pkg::LEN_W'($urandom),
              fsw_pkg::ID_W'($urandom));
    end
  endtask

  // wait for every expected result, then for the block to settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // idle block: new timeout, then a run of random operations
  task automatic run_phase(input logic [fsw_pkg::TIMER_W-1:0] timeout_val, input bit last);
    int unsigned n;
    bit          counted;
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= timeout_val;
    gaps_on <= !last;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n = 0;
    while (n < PHASE_ITEMS) begin
      random_op(counted);
      if (counted) begin
        n++;
        // stretches with and without idling
        if (!last && n % 48 == 47) gaps_on <= ($urandom_range(0, 3) != 0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, ignored operations and all-ones noise
    send_op(fsw_pkg::FUNC_RESEND, '0, '0);
    send_op(fsw_pkg::FUNC_ACK_OK, '1, '1);
    send_op(fsw_pkg::FUNC_ACK_ER, '0, '0);
    send_op(fsw_pkg::FUNC_TICK, '0, '0);
    send_op(fsw_pkg::FUNC_PUT, '0, '1);
    for (int k = 1; k <= 3; k++) send_op(3'(fsw_pkg::FUNC_TICK + k), '1, '1);
    // size class boundaries; first put goes out at once
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(1), '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(8), '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(9), '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(32), '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(33), '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(128), '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(129), '0);
    // mismatched and matching ok, error, resend, a quiet tick
    send_op(fsw_pkg::FUNC_ACK_OK, '0, head_id() + 1'b1);
    send_op(fsw_pkg::FUNC_ACK_OK, '0, head_id());
    send_op(fsw_pkg::FUNC_ACK_ER, '0, '0);
    send_op(fsw_pkg::FUNC_RESEND, '0, '0);
    send_op(fsw_pkg::FUNC_TICK, '0, '0);
    // clipped overlong messages overflowing the queue
    send_op(fsw_pkg::FUNC_PUT, '1, '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(MAX_MSG), '0);
    send_op(fsw_pkg::FUNC_PUT, fsw_pkg::LEN_W'(MAX_MSG + 1), '0);
    send_op(fsw_pkg::FUNC_ACK_OK, '0, head_id());
    send_op(fsw_pkg::FUNC_TICK, '0, '0);
    send_op(fsw_pkg::FUNC_ACK_OK, '0, head_id());

    // timeout settings, extremes included; last phase has no idling
    run_phase(fsw_pkg::TIMER_W'(1), 1'b0);
    run_phase(fsw_pkg::TIMER_W'(0), 1'b0);
    run_phase(fsw_pkg::TIMER_W'(4), 1'b0);
    run_phase('1, 1'b0);
    run_phase(fsw_pkg::TIMER_W'(20), 1'b0);
    run_phase(fsw_pkg::TIMER_W'(2), 1'b1);
    drain();

    if (error_count == 0 && pending_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
